/* design/stq_pkg.sv */
package stq_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_BITS_DEF  = 48;

   // expiries reported by one tick at most
   localparam int EXPIRY_CAP = 64;
   localparam int CNT_W      = $clog2(EXPIRY_CAP + 1);
   localparam int EXP_AW     = $clog2(EXPIRY_CAP);

   typedef enum logic [1:0] {
      ACT_SET    = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_TICK   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_SET    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_EXPIRY = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_PENDING  = 2'd1,
      STAT_BAD_IVAL = 2'd2
   } status_type;

endpackage

/* design/sorted_timer_queue.sv */
// Sorted timer queue. Up to NUM_TIMERS timer slots are kept in one doubly
// linked list ordered by deadline, earliest first; links live in one
// synchronous RAM and deadline/interval pairs in another, both with a
// registered read. A set request arms an idle slot (one-shot at an absolute
// deadline, periodic at now plus interval) and gets one reply; a cancel
// request unlinks the slot and gets one reply; a tick request pops every due
// head (at most 64), re-arming periodic slots, and reports each expiry after
// the whole tick is done so that head_valid/head_deadline on every result
// reflect the final list. Requests are taken one at a time. An insert walks
// the list back from the tail (up to NUM_TIMERS entries); a tick re-inserts
// each periodic re-arm that way and replays its results from the expiry
// buffer RAM. A new request is taken while the last result still waits in
// the output register.
module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int ID_W       = $clog2(NUM_TIMERS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic [ID_W-1:0]             req_timer_id,
   input  logic                        req_periodic,
   input  logic signed [TIME_BITS-1:0] req_time_value,
   input  logic [TIME_BITS-2:0]        req_now,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_was_pending,
   output logic [ID_W-1:0]             rsp_expired_id,
   output logic                        rsp_more_pending,
   output logic                        rsp_head_valid,
   output logic signed [TIME_BITS-1:0] rsp_head_deadline,
   output logic                        rsp_last
);

   localparam int TB = TIME_BITS;
   localparam int LW = $clog2(NUM_TIMERS + 1);
   localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);
   localparam logic signed [TB-1:0] TMAX = {1'b0, {(TB-1){1'b1}}};

   typedef struct packed {
      logic [LW-1:0] nxt;
      logic [LW-1:0] prv;
   } link_type;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_TICK    = 14'b00000000000010,
      S_UL_RD   = 14'b00000000000100,
      S_UL_PW   = 14'b00000000001000,
      S_UL_NW   = 14'b00000000010000,
      S_UL_END  = 14'b00000000100000,
      S_INS     = 14'b00000001000000,
      S_INS_HW  = 14'b00000010000000,
      S_WALK    = 14'b00000100000000,
      S_INS_S   = 14'b00001000000000,
      S_INS_NW  = 14'b00010000000000,
      S_REPLY   = 14'b00100000000000,
      S_EMIT_RD = 14'b01000000000000,
      S_EMIT_LD = 14'b10000000000000
   } state_type;

   // saturating add, b known positive
   function automatic logic signed [TB-1:0] sat_add(input logic signed [TB-1:0] a,
                                                    input logic signed [TB-1:0] b);
      logic signed [TB:0] s;
      s = {a[TB-1], a} + {b[TB-1], b};
      if (s[TB] != s[TB-1]) begin
         return TMAX;
      end
      return s[TB-1:0];
   endfunction

   // control and working registers
   state_type            state_ff, state_in;
   logic [ID_W-1:0]      slot_ff, slot_in;
   logic [LW-1:0]        walk_ff, walk_in;
   logic [LW-1:0]        prv_ff, prv_in;
   logic [LW-1:0]        nxt_ff, nxt_in;
   logic [LW-1:0]        head_ff, head_in;
   logic [LW-1:0]        tail_ff, tail_in;
   logic signed [TB-1:0] hdl_ff, hdl_in;     // deadline of list head, cached
   logic signed [TB-1:0] dl_ff, dl_in;       // deadline being inserted
   logic signed [TB-1:0] odl_ff, odl_in;     // deadline of popped slot
   logic signed [TB-1:0] ival_ff, ival_in;
   logic [TB-2:0]        now_ff, now_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [EXP_AW-1:0]    k_ff, k_in;
   logic                 tick_ff, tick_in;
   logic                 more_ff, more_in;
   logic                 was_ff, was_in;
   logic [1:0]           kind_ff, kind_in;
   logic [1:0]           status_ff, status_in;
   logic [NUM_TIMERS-1:0] pend_ff, pend_in;
   logic [NUM_TIMERS-1:0] per_ff, per_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 rsp_was_ff, rsp_was_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                 rsp_more_ff, rsp_more_in;
   logic                 rsp_hv_ff, rsp_hv_in;
   logic signed [TB-1:0] rsp_hd_ff, rsp_hd_in;
   logic                 rsp_last_ff, rsp_last_in;

   // memory ports
   logic                 lk_we;
   logic [ID_W-1:0]      lk_waddr, lk_raddr;
   link_type             lk_wdata, lk_rd;
   logic                 tm_we;
   logic [ID_W-1:0]      tm_waddr, tm_raddr;
   logic [2*TB-1:0]      tm_wdata, tm_rd;
   logic signed [TB-1:0] tm_rd_dl, tm_rd_iv;
   logic                 id_we;
   logic [EXP_AW-1:0]    id_waddr, id_raddr;
   logic [ID_W-1:0]      id_wdata, id_rd;

   logic                 rsp_free;
   logic                 due;
   logic                 id_ok;
   logic                 is_last;
   logic [LW-1:0]        slot_ext;
   logic signed [TB-1:0] new_dl;

   stq_ram #(.WIDTH(2 * LW), .DEPTH(NUM_TIMERS), .AW(ID_W)) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (lk_raddr),
      .rd_data (lk_rd)
   );

   stq_ram #(.WIDTH(2 * TB), .DEPTH(NUM_TIMERS), .AW(ID_W)) u_time_ram (
      .clock   (clock),
      .wr_en   (tm_we),
      .wr_addr (tm_waddr),
      .wr_data (tm_wdata),
      .rd_addr (tm_raddr),
      .rd_data (tm_rd)
   );

   // ids of one tick's expiries, replayed once the tick settles
   stq_ram #(.WIDTH(ID_W), .DEPTH(EXPIRY_CAP), .AW(EXP_AW)) u_exp_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (id_wdata),
      .rd_addr (id_raddr),
      .rd_data (id_rd)
   );

   assign tm_rd_dl = tm_rd[2*TB-1:TB];
   assign tm_rd_iv = tm_rd[TB-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign due      = (head_ff != NIL) && ($signed({1'b0, now_ff}) >= hdl_ff);
   assign id_ok    = 32'(req_timer_id) < NUM_TIMERS;
   assign slot_ext = LW'(slot_ff);
   assign is_last  = (CNT_W'(k_ff) + CNT_W'(1)) == cnt_ff;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      walk_in   = walk_ff;
      prv_in    = prv_ff;
      nxt_in    = nxt_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      hdl_in    = hdl_ff;
      dl_in     = dl_ff;
      odl_in    = odl_ff;
      ival_in   = ival_ff;
      now_in    = now_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      tick_in   = tick_ff;
      more_in   = more_ff;
      was_in    = was_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      pend_in   = pend_ff;
      per_in    = per_ff;
      new_dl    = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_was_in    = rsp_was_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_more_in   = rsp_more_ff;
      rsp_hv_in     = rsp_hv_ff;
      rsp_hd_in     = rsp_hd_ff;
      rsp_last_in   = rsp_last_ff;

      lk_we    = 1'b0;
      lk_waddr = slot_ff;
      lk_wdata = '{nxt: NIL, prv: NIL};
      lk_raddr = slot_ff;
      tm_we    = 1'b0;
      tm_waddr = slot_ff;
      tm_wdata = {dl_ff, ival_ff};
      tm_raddr = slot_ff;
      id_we    = 1'b0;
      id_waddr = cnt_ff[EXP_AW-1:0];
      id_wdata = head_ff[ID_W-1:0];
      id_raddr = k_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in    = req_now;
               slot_in   = req_timer_id;
               tick_in   = 1'b0;
               more_in   = 1'b0;
               was_in    = 1'b0;
               status_in = STAT_OK;
               case (req_action)
                  ACT_SET: begin
                     kind_in = KIND_SET;
                     if (!id_ok || pend_ff[req_timer_id]) begin
                        status_in = STAT_PENDING;
                        state_in  = S_REPLY;
                     end else if (req_periodic && req_time_value <= 0) begin
                        status_in = STAT_BAD_IVAL;
                        state_in  = S_REPLY;
                     end else begin
                        per_in[req_timer_id]  = req_periodic;
                        pend_in[req_timer_id] = 1'b1;
                        new_dl = req_periodic ?
                                 sat_add($signed({1'b0, req_now}), req_time_value) :
                                 req_time_value;
                        dl_in    = new_dl;
                        tm_we    = 1'b1;
                        tm_waddr = req_timer_id;
                        tm_wdata = {new_dl, req_time_value};
                        state_in = S_INS;
                     end
                  end
                  ACT_CANCEL: begin
                     kind_in = KIND_CANCEL;
                     if (id_ok && pend_ff[req_timer_id]) begin
                        pend_in[req_timer_id] = 1'b0;
                        was_in   = 1'b1;
                        lk_raddr = req_timer_id;
                        tm_raddr = req_timer_id;
                        state_in = S_UL_RD;
                     end else begin
                        state_in = S_REPLY;
                     end
                  end
                  default: begin
                     // tick; the unused code behaves as a tick too
                     tick_in  = 1'b1;
                     cnt_in   = '0;
                     state_in = S_TICK;
                  end
               endcase
            end
         end

         S_TICK: begin
            if (cnt_ff < CNT_W'(EXPIRY_CAP) && due) begin
               slot_in  = head_ff[ID_W-1:0];
               id_we    = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               lk_raddr = head_ff[ID_W-1:0];
               tm_raddr = head_ff[ID_W-1:0];
               state_in = S_UL_RD;
            end else if (cnt_ff == '0) begin
               kind_in  = KIND_NONE;
               state_in = S_REPLY;
            end else begin
               more_in  = due;
               k_in     = '0;
               state_in = S_EMIT_RD;
            end
         end

         // unlink: links and times of the slot are on the read ports
         S_UL_RD: begin
            prv_in  = lk_rd.prv;
            nxt_in  = lk_rd.nxt;
            odl_in  = tm_rd_dl;
            ival_in = tm_rd_iv;
            if (lk_rd.prv != NIL) begin
               lk_raddr = lk_rd.prv[ID_W-1:0];
               state_in = S_UL_PW;
            end else begin
               head_in = lk_rd.nxt;
               if (lk_rd.nxt != NIL) begin
                  lk_raddr = lk_rd.nxt[ID_W-1:0];
                  tm_raddr = lk_rd.nxt[ID_W-1:0];
                  state_in = S_UL_NW;
               end else begin
                  tail_in  = NIL;
                  state_in = S_UL_END;
               end
            end
         end

         S_UL_PW: begin
            lk_we    = 1'b1;
            lk_waddr = prv_ff[ID_W-1:0];
            lk_wdata = '{nxt: nxt_ff, prv: lk_rd.prv};
            if (nxt_ff != NIL) begin
               lk_raddr = nxt_ff[ID_W-1:0];
               state_in = S_UL_NW;
            end else begin
               tail_in  = prv_ff;
               state_in = S_UL_END;
            end
         end

         S_UL_NW: begin
            lk_we    = 1'b1;
            lk_waddr = nxt_ff[ID_W-1:0];
            lk_wdata = '{nxt: lk_rd.nxt, prv: prv_ff};
            if (prv_ff == NIL) begin
               hdl_in = tm_rd_dl;
            end
            state_in = S_UL_END;
         end

         S_UL_END: begin
            if (!tick_ff) begin
               state_in = S_REPLY;
            end else if (per_ff[slot_ff] && ival_ff > 0) begin
               new_dl   = sat_add(odl_ff, ival_ff);
               dl_in    = new_dl;
               tm_we    = 1'b1;
               tm_wdata = {new_dl, ival_ff};
               state_in = S_INS;
            end else begin
               pend_in[slot_ff] = 1'b0;
               state_in = S_TICK;
            end
         end

         S_INS: begin
            if (head_ff == NIL) begin
               lk_we    = 1'b1;
               head_in  = slot_ext;
               tail_in  = slot_ext;
               hdl_in   = dl_ff;
               state_in = tick_ff ? S_TICK : S_REPLY;
            end else if (hdl_ff >= dl_ff) begin
               // equal deadlines: the new entry goes first
               lk_we    = 1'b1;
               lk_wdata = '{nxt: head_ff, prv: NIL};
               lk_raddr = head_ff[ID_W-1:0];
               walk_in  = head_ff;
               state_in = S_INS_HW;
            end else begin
               walk_in  = tail_ff;
               lk_raddr = tail_ff[ID_W-1:0];
               tm_raddr = tail_ff[ID_W-1:0];
               state_in = S_WALK;
            end
         end

         S_INS_HW: begin
            lk_we    = 1'b1;
            lk_waddr = walk_ff[ID_W-1:0];
            lk_wdata = '{nxt: lk_rd.nxt, prv: slot_ext};
            head_in  = slot_ext;
            hdl_in   = dl_ff;
            state_in = tick_ff ? S_TICK : S_REPLY;
         end

         // walk back from the tail; the head is known earlier, so this stops
         S_WALK: begin
            if (tm_rd_dl < dl_ff) begin
               lk_we    = 1'b1;
               lk_waddr = walk_ff[ID_W-1:0];
               lk_wdata = '{nxt: slot_ext, prv: lk_rd.prv};
               nxt_in   = lk_rd.nxt;
               state_in = S_INS_S;
            end else begin
               walk_in  = lk_rd.prv;
               lk_raddr = lk_rd.prv[ID_W-1:0];
               tm_raddr = lk_rd.prv[ID_W-1:0];
            end
         end

         S_INS_S: begin
            lk_we    = 1'b1;
            lk_wdata = '{nxt: nxt_ff, prv: walk_ff};
            if (nxt_ff != NIL) begin
               lk_raddr = nxt_ff[ID_W-1:0];
               state_in = S_INS_NW;
            end else begin
               tail_in  = slot_ext;
               state_in = tick_ff ? S_TICK : S_REPLY;
            end
         end

         S_INS_NW: begin
            lk_we    = 1'b1;
            lk_waddr = nxt_ff[ID_W-1:0];
            lk_wdata = '{nxt: lk_rd.nxt, prv: slot_ext};
            state_in = tick_ff ? S_TICK : S_REPLY;
         end

         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = kind_ff;
               rsp_status_in = status_ff;
               rsp_was_in    = was_ff;
               rsp_id_in     = '0;
               rsp_more_in   = 1'b0;
               rsp_hv_in     = head_ff != NIL;
               rsp_hd_in     = (head_ff != NIL) ? hdl_ff : '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end

         S_EMIT_LD: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_EXPIRY;
               rsp_status_in = STAT_OK;
               rsp_was_in    = 1'b0;
               rsp_id_in     = id_rd;
               rsp_more_in   = is_last && more_ff;
               rsp_hv_in     = head_ff != NIL;
               rsp_hd_in     = (head_ff != NIL) ? hdl_ff : '0;
               rsp_last_in   = is_last;
               k_in          = k_ff + EXP_AW'(1);
               state_in      = is_last ? S_IDLE : S_EMIT_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         pend_ff      <= '0;
         per_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         tick_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         pend_ff      <= pend_in;
         per_ff       <= per_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         tick_ff      <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      walk_ff       <= walk_in;
      prv_ff        <= prv_in;
      nxt_ff        <= nxt_in;
      hdl_ff        <= hdl_in;
      dl_ff         <= dl_in;
      odl_ff        <= odl_in;
      ival_ff       <= ival_in;
      now_ff        <= now_in;
      more_ff       <= more_in;
      was_ff        <= was_in;
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_was_ff    <= rsp_was_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_more_ff   <= rsp_more_in;
      rsp_hv_ff     <= rsp_hv_in;
      rsp_hd_ff     <= rsp_hd_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_was_pending   = rsp_was_ff;
   assign rsp_expired_id    = rsp_id_ff;
   assign rsp_more_pending  = rsp_more_ff;
   assign rsp_head_valid    = rsp_hv_ff;
   assign rsp_head_deadline = rsp_hd_ff;
   assign rsp_last          = rsp_last_ff;

   // list ends agree whenever no request is in flight
   a_ends_agree: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> ((head_ff == NIL) == (tail_ff == NIL)))
      else $error("head and tail disagree on empty list");

   // an empty list means no slot is pending
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> ((head_ff == NIL) == (pend_ff == '0)))
      else $error("pending slots do not match list occupancy");

   // the backward walk never runs off the head
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> walk_ff != NIL)
      else $error("insert walk reached list end");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(EXPIRY_CAP))
      else $error("expiry count beyond cap");

   // a result is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_expired_id))
      else $error("pending result overwritten");

endmodule

/* design/stq_ram.sv */
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import stq_pkg::*;

   localparam int NT = 16;
   localparam int TB = 48;
   localparam longint TMAX = (64'sd1 <<< (TB - 1)) - 1;
   localparam int NIL = NT;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = ACT_TICK;
   logic [3:0] req_timer_id = '0;
   logic req_periodic = 1'b0;
   logic signed [TB-1:0] req_time_value = '0;
   logic [TB-2:0] req_now = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [1:0] rsp_status;
   logic rsp_was_pending;
   logic [3:0] rsp_expired_id;
   logic rsp_more_pending;
   logic rsp_head_valid;
   logic signed [TB-1:0] rsp_head_deadline;
   logic rsp_last;

   sorted_timer_queue dut (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] status;
      logic was_pending;
      logic [3:0] expired_id;
      logic more_pending;
      logic head_valid;
      logic signed [TB-1:0] head_deadline;
      logic last;
   } reply_t;

   // shadow of the timer list
   longint t_deadline[NT];
   longint t_interval[NT];
   bit t_periodic[NT];
   bit t_pending[NT];
   int t_next[NT];
   int t_prev[NT];
   int t_head, t_tail;

   reply_t replies_due[$];
   int errors = 0;
   int mismatches = 0;
   bit idle_enable = 1'b1;
   bit rsp_hold = 1'b0;
   longint sim_now = 0;

   function automatic longint add_sat(longint a, longint b);
      if (a > TMAX - b) return TMAX;
      return a + b;
   endfunction

   function automatic void list_unlink(int s);
      int p, n;
      p = t_prev[s];
      n = t_next[s];
      if (p < NIL) t_next[p] = n; else t_head = n;
      if (n < NIL) t_prev[n] = p; else t_tail = p;
      t_next[s] = NIL;
      t_prev[s] = NIL;
   endfunction

   // new entry goes ahead of equal deadlines
   function automatic void list_insert(int s);
      longint d;
      int t, n;
      d = t_deadline[s];
      if (t_head >= NIL) begin
         t_head = s;
         t_tail = s;
         t_next[s] = NIL;
         t_prev[s] = NIL;
         return;
      end
      if (t_deadline[t_head] >= d) begin
         t_next[s] = t_head;
         t_prev[s] = NIL;
         t_prev[t_head] = s;
         t_head = s;
         return;
      end
      t = t_tail;
      for (int g = 0; g < NT && t < NIL; g++) begin
         if (t_deadline[t] < d) begin
            n = t_next[t];
            t_prev[s] = t;
            t_next[s] = n;
            t_next[t] = s;
            if (n < NIL) t_prev[n] = s; else t_tail = s;
            return;
         end
         t = t_prev[t];
      end
   endfunction

   function automatic void predict_request(logic [1:0] act, int id, bit per,
                                           longint tv, longint now);
      reply_t r[$];
      reply_t one;
      one = '0;
      if (act == ACT_SET) begin
         if (t_pending[id]) one.status = STAT_PENDING;
         else if (per && tv <= 0) one.status = STAT_BAD_IVAL;
         else begin
            t_periodic[id] = per;
            t_pending[id] = 1'b1;
            if (per) begin
               t_interval[id] = tv;
               t_deadline[id] = add_sat(now, tv);
            end else t_deadline[id] = tv;
            list_insert(id);
         end
         one.kind = KIND_SET;
         r.push_back(one);
      end else if (act == ACT_CANCEL) begin
         if (t_pending[id]) begin
            list_unlink(id);
            t_pending[id] = 1'b0;
            one.was_pending = 1'b1;
         end
         one.kind = KIND_CANCEL;
         r.push_back(one);
      end else begin
         // tick, and the unused action code behaves as one
         while (r.size() < EXPIRY_CAP && t_head < NIL && now >= t_deadline[t_head]) begin
            int s;
            s = t_head;
            list_unlink(s);
            if (t_periodic[s] && t_interval[s] > 0) begin
               t_deadline[s] = add_sat(t_deadline[s], t_interval[s]);
               list_insert(s);
            end else t_pending[s] = 1'b0;
            one = '0;
            one.kind = KIND_EXPIRY;
            one.expired_id = s[3:0];
            r.push_back(one);
         end
         if (r.size() == 0) begin
            one = '0;
            one.kind = KIND_NONE;
            r.push_back(one);
         end else if (r.size() == EXPIRY_CAP && t_head < NIL
                      && now >= t_deadline[t_head])
            r[r.size() - 1].more_pending = 1'b1;
      end
      // head fields reflect the list after the whole request
      foreach (r[k]) begin
         if (t_head < NIL) begin
            r[k].head_valid = 1'b1;
            r[k].head_deadline = t_deadline[t_head];
         end
         r[k].last = (k == r.size() - 1);
         replies_due.push_back(r[k]);
      end
   endfunction

   // one request through the handshake, with random idle bursts ahead
   task automatic send_request(logic [1:0] act, int id, bit per, longint tv, longint now);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_timer_id <= id[3:0];
      req_periodic <= per;
      req_time_value <= tv[TB-1:0];
      req_now <= now[TB-2:0];
      predict_request(act, id, per, tv, now);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // result receiver: random stalls unless held or in the quiet tail
   always @(negedge clock) begin
      if (reset || rsp_hold) rsp_ready <= 1'b0;
      else if (idle_enable && $urandom_range(0, 4) == 0) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      reply_t got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_status, rsp_was_pending, rsp_expired_id,
                rsp_more_pending, rsp_head_valid, rsp_head_deadline, rsp_last};
         if (replies_due.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected reply %p", got);
         end else begin
            want = replies_due.pop_front();
            if (got !== want) begin
               errors++;
               if (mismatches++ < 10) $display("reply mismatch: exp %p got %p", want, got);
            end
         end
      end
   end

   function automatic longint rand_time();
      longint v;
      v = {$urandom(), $urandom()};
      return (v <<< 16) >>> 16;
   endfunction

   task automatic test_set_cancel_edges();
      send_request(ACT_TICK, 0, 0, 0, 0);
      send_request(ACT_SET, 0, 0, -TMAX - 1, 0);
      send_request(ACT_SET, 0, 0, 5, 0);              // already pending
      send_request(ACT_SET, 15, 1, 0, 10);            // zero interval
      send_request(ACT_SET, 15, 1, -3, 10);           // negative interval
      send_request(ACT_SET, 15, 1, TMAX, TMAX);       // saturates
      send_request(ACT_SET, 3, 0, TMAX, 0);
      send_request(ACT_SET, 4, 0, 100, 0);
      send_request(ACT_SET, 5, 0, 100, 0);            // ahead of equal
      send_request(ACT_SET, 6, 1, 1, 99);
      send_request(ACT_CANCEL, 4, 0, 0, 0);
      send_request(ACT_CANCEL, 4, 0, 0, 0);
      send_request(ACT_TICK, 0, 0, 0, 0);
      send_request(ACT_TICK, 0, 0, 0, 150);
      send_request(2'd3, 0, 0, 0, TMAX);              // unused code ticks
      send_request(ACT_TICK, 0, 0, 0, TMAX);
      for (int i = 0; i < NT; i++) send_request(ACT_CANCEL, i, 0, 0, 0);
      wait_drained();
   endtask

   // periodic timers with interval 1 hit the expiry cap
   task automatic test_expiry_cap();
      for (int i = 0; i < 4; i++) send_request(ACT_SET, i, 1, 1, 0);
      send_request(ACT_TICK, 0, 0, 0, 40);
      send_request(ACT_TICK, 0, 0, 0, 40);
      send_request(ACT_TICK, 0, 0, 0, 40);
      for (int i = 0; i < 4; i++) send_request(ACT_CANCEL, i, 0, 0, 0);
      wait_drained();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 12; i++)
            send_request(i % 3 == 2 ? ACT_TICK : ACT_SET, i, i[0], 1 + i, i * 2);
      join
      wait_drained();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         int sel, id;
         longint tv;
         sel = $urandom_range(0, 99);
         id = $urandom_range(0, NT - 1);
         if (i == count - 80) idle_enable = 1'b0;
         if ($urandom_range(0, 3) != 0) sim_now += $urandom_range(0, 40);
         if (sim_now > TMAX - 1000) sim_now = 0;
         if (sel < 40) begin
            case ($urandom_range(0, 5))
               0: tv = rand_time();
               1: tv = TMAX - $urandom_range(0, 50);
               default: tv = sim_now + $urandom_range(0, 200) - 20;
            endcase
            send_request(ACT_SET, id, 1'b0, tv, sim_now);
         end else if (sel < 60) begin
            case ($urandom_range(0, 4))
               0: tv = rand_time();
               1: tv = -longint'($urandom_range(0, 5));
               default: tv = $urandom_range(1, 60);
            endcase
            send_request(ACT_SET, id, 1'b1, tv, sim_now);
         end else if (sel < 75) send_request(ACT_CANCEL, id, 0, rand_time(), sim_now);
         else if (sel < 97) send_request(ACT_TICK, id, $urandom_range(0, 1), rand_time(), sim_now);
         else send_request(2'd3, id, 0, rand_time(), {$urandom(), $urandom()} & TMAX);
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NT; i++) begin
         t_pending[i] = 0;
         t_periodic[i] = 0;
      end
      t_head = NIL;
      t_tail = NIL;
      test_set_cancel_edges();
      test_expiry_cap();
      test_backpressure();
      test_random(420);
      if (errors == 0 && replies_due.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
design/stq_pkg.sv
design/stq_ram.sv
design/sorted_timer_queue.sv
test/tb_top.sv
